@@ rtl/mlrrf_pkg.sv @@
// ----------------------------------------------------------------------------
// mlrrf_pkg
// Shared types and constants for the mac learning round-robin forwarder.
// ----------------------------------------------------------------------------
package mlrrf_pkg;

  // default sizes and codes
  localparam int unsigned TableDepthDef = 64;
  localparam logic [15:0] FloodCodeDef  = 16'd65531;

  // field widths
  localparam int unsigned PortW  = 16;
  localparam int unsigned MacW   = 48;
  localparam int unsigned IpW    = 32;
  localparam int unsigned SrvCntW = 9;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_SERVER_IP    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SERVER_COUNT = 2'd1;

  // register reset values (server address 10.1.1.254)
  localparam logic [IpW-1:0]     ServerIpRst    = 32'h0A01_01FE;
  localparam logic [SrvCntW-1:0] ServerCountRst = 9'd4;

  // all-ones destination means broadcast
  localparam logic [MacW-1:0] BcastMac = {MacW{1'b1}};

  // one station table entry
  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

endpackage

@@ rtl/mac_learning_round_robin_forwarder.sv @@
// ----------------------------------------------------------------------------
// mac_learning_round_robin_forwarder
// Learns source addresses into a station table and picks an egress port per
// packet-in word: broadcast or fallback flood, learned port, ingress port, or round-robin server port.
// ----------------------------------------------------------------------------
// The station table has a single read port, and both the source and the
// destination address are matched against each stored entry as it streams
// out, one entry per cycle; the match on each entry is taken from the
// registered read data, the scan then closes, and the decide step picks the
// port, learns the new station and updates the round-robin position, waiting
// while a stalled result word still holds the output register. The next
// packet-in word is accepted once the sequencer is back in idle after the
// result word is registered. Entries are stored in order and never aged,
// so the fill count alone marks which entries are valid and no clearing pass
// is needed after reset. A finished word waits in the output register while
// the next packet-in word is accepted and scanned.
module mac_learning_round_robin_forwarder #(
  parameter int unsigned TABLE_DEPTH = mlrrf_pkg::TableDepthDef,
  parameter logic [15:0] FLOOD_CODE  = mlrrf_pkg::FloodCodeDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mlrrf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mlrrf_pkg::CfgDataW-1:0]   cfg_data_i,
  // packet-in channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mlrrf_pkg::PortW-1:0]      ingress_port_i,
  input  logic [mlrrf_pkg::MacW-1:0]       source_mac_i,
  input  logic [mlrrf_pkg::MacW-1:0]       dest_mac_i,
  input  logic [mlrrf_pkg::IpW-1:0]        source_ip_i,
  input  logic [mlrrf_pkg::IpW-1:0]        dest_ip_i,
  // decision channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mlrrf_pkg::PortW-1:0]      egress_port_o,
  output logic                             flood_o,
  output logic                             learn_dropped_o
);
  import mlrrf_pkg::*;

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  // configuration registers
  logic [IpW-1:0]     server_ip_q;
  logic [SrvCntW-1:0] server_count_q;

  // sequencer and table bookkeeping
  state_e          state_q, state_d;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] addr_q;
  logic            pend_q;
  logic            src_hit_q;
  logic            dst_hit_q;
  logic [PortW-1:0] dst_port_q;

  // round-robin position
  logic             rr_started_q;
  logic [PortW-1:0] rr_last_q;

  // captured packet-in word
  logic [PortW-1:0] in_port_q;
  logic [MacW-1:0]  src_mac_q;
  logic [MacW-1:0]  dst_mac_q;
  logic [IpW-1:0]   src_ip_q;
  logic [IpW-1:0]   dst_ip_q;

  // output register
  logic             out_valid_q;
  logic [PortW-1:0] out_port_q;
  logic             out_flood_q;
  logic             out_drop_q;

  // station table
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_q;

  logic in_accept;
  logic out_free;
  logic rd_en;
  logic scan_done;
  logic decide_go;
  logic learn;
  logic store;
  logic dropped;
  logic [PortW:0]   rr_sum;
  logic [PortW-1:0] rr_next;
  logic             is_bcast;
  logic             self_hit;
  logic             to_server;
  logic [PortW-1:0] res_port;
  logic             res_flood;
  logic             use_rr;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_done   = (addr_q == fill_q) && !pend_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_ip_q    <= ServerIpRst;
      server_count_q <= ServerCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SERVER_IP:    server_ip_q    <= cfg_data_i[IpW-1:0];
        CFG_SERVER_COUNT: server_count_q <= cfg_data_i[SrvCntW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: if (out_free)  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    decide_go  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SCAN:   rd_en      = (addr_q != fill_q);
      ST_DECIDE: decide_go  = out_free;
      default: ;
    endcase
  end

  // decision for the captured word
  always_comb begin
    learn    = !src_hit_q;
    store    = learn && (fill_q < DepthCnt);
    dropped  = learn && !(fill_q < DepthCnt);
    is_bcast = (dst_mac_q == BcastMac);
    // a freshly learned source that is also the destination
    self_hit = store && (dst_mac_q == src_mac_q);
    to_server = (src_ip_q != '0) && (dst_ip_q == server_ip_q);
    rr_sum   = {1'b0, rr_last_q} + {{PortW{1'b0}}, 1'b1};
    if (!rr_started_q) begin
      rr_next = '0;
    end else if (rr_sum >= {{(PortW+1-SrvCntW){1'b0}}, server_count_q}) begin
      rr_next = '0;
    end else begin
      rr_next = rr_sum[PortW-1:0];
    end
    use_rr    = 1'b0;
    res_port  = FLOOD_CODE;
    res_flood = 1'b1;
    priority if (is_bcast) begin
      res_port  = FLOOD_CODE;
      res_flood = 1'b1;
    end else if (dst_hit_q) begin
      res_port  = dst_port_q;
      res_flood = 1'b0;
    end else if (self_hit) begin
      res_port  = in_port_q;
      res_flood = 1'b0;
    end else if (to_server) begin
      use_rr    = 1'b1;
      res_port  = rr_next;
      res_flood = 1'b0;
    end else begin
      // unknown destination, arp probe or not for the server
      res_port  = FLOOD_CODE;
      res_flood = 1'b1;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (decide_go && store) begin
      mem[fill_q[AddrW-1:0]] <= '{mac: src_mac_q, port: in_port_q};
    end
    if (rd_en) begin
      rd_data_q <= mem[addr_q[AddrW-1:0]];
    end
  end

  // captured word, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_port_q <= ingress_port_i;
      src_mac_q <= source_mac_i;
      dst_mac_q <= dest_mac_i;
      src_ip_q  <= source_ip_i;
      dst_ip_q  <= dest_ip_i;
    end
  end

  // sequencer, scan and learn bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      addr_q       <= '0;
      pend_q       <= 1'b0;
      src_hit_q    <= 1'b0;
      dst_hit_q    <= 1'b0;
      dst_port_q   <= '0;
      rr_started_q <= 1'b0;
      rr_last_q    <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (in_accept) begin
        addr_q    <= '0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else begin
        if (rd_en) begin
          addr_q <= addr_q + {{(CntW-1){1'b0}}, 1'b1};
        end
        // match the entry read last cycle
        if (pend_q) begin
          if (rd_data_q.mac == src_mac_q) begin
            src_hit_q <= 1'b1;
          end
          if (rd_data_q.mac == dst_mac_q && !dst_hit_q) begin
            dst_hit_q  <= 1'b1;
            dst_port_q <= rd_data_q.port;
          end
        end
      end
      if (decide_go) begin
        if (store) begin
          fill_q <= fill_q + {{(CntW-1){1'b0}}, 1'b1};
        end
        if (use_rr) begin
          rr_started_q <= 1'b1;
          rr_last_q    <= rr_next;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (decide_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_go) begin
      out_port_q  <= res_port;
      out_flood_q <= res_flood;
      out_drop_q  <= dropped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign egress_port_o   = out_port_q;
  assign flood_o         = out_flood_q;
  assign learn_dropped_o = out_drop_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthCnt)
    else $error("fill count beyond table depth");

  a_out_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DECIDE)
    else $error("result word without a decision");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_SCAN && addr_q == '0)
    else $error("accepted word did not start a scan");

  a_flood_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flood_q |-> out_port_q == FLOOD_CODE)
    else $error("flood without flood code");

endmodule
